/* hdl/bdtw_pkg.sv */
// ----------------------------------------------------------------------------
// bdtw_pkg
// Shared widths, defaults and codes for the banded DTW distance unit.
// ----------------------------------------------------------------------------
package bdtw_pkg;

	localparam int MAX_LEN_DEF     = 256;
	localparam int MAX_RADIUS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int RADIUS_W   = 6;
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 9;
	localparam int STATUS_W   = 2;
	localparam int COST_SUM_W = 40;
	localparam int DIST_W     = 20;
	localparam int PLEN_W     = 9;
	localparam int PPOS_W     = 8;
	localparam int TR_W       = 2;

	localparam int COST_SAT_W = 41;
	localparam logic [COST_SAT_W-1:0] COST_INF = 41'h1FF_FFFF_FFFF;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

	localparam logic [TR_W-1:0] TR_LEFT = 2'd0;
	localparam logic [TR_W-1:0] TR_DIAG = 2'd1;
	localparam logic [TR_W-1:0] TR_UP   = 2'd2;

endpackage

/* hdl/banded_dtw_distance_with_path_unit.sv */
// A stored plain pair gives no answer; a valid path read answers via ST_PREAD. A final pair
// runs the band fill (ST_C_RD0, ST_C_RD1, ST_C_SQ, ST_C_WR per cell, ST_C_ROW per row; the
// two cost row reads share one read port), the square root, traceback (ST_T_RD, ST_T_EV per
// step), then the answer. One request at a time; new requests wait until the current one
// has answered. Reset clears control state, the radius, the load count and the results; the
// sample, cost row, trace and path memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// banded_dtw_distance_with_path_unit
// Banded dynamic time warping with squared-difference cost, traceback and path readout.
// ----------------------------------------------------------------------------
module banded_dtw_distance_with_path_unit #(
	parameter int MAX_LEN     = bdtw_pkg::MAX_LEN_DEF,
	parameter int MAX_RADIUS  = bdtw_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_BITS = bdtw_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdtw_pkg::RADIUS_W-1:0]         band_radius,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  kind,
	input  logic signed [bdtw_pkg::SAMPLE_W-1:0]  sample_a,
	input  logic signed [bdtw_pkg::SAMPLE_W-1:0]  sample_b,
	input  logic                                  last_pair,
	input  logic [bdtw_pkg::STEP_W-1:0]           step_index,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [bdtw_pkg::STATUS_W-1:0]         status,
	output logic [bdtw_pkg::COST_SUM_W-1:0]       cost_sum,
	output logic [bdtw_pkg::DIST_W-1:0]           distance,
	output logic [bdtw_pkg::PLEN_W-1:0]           path_length,
	output logic [bdtw_pkg::PPOS_W-1:0]           path_row,
	output logic [bdtw_pkg::PPOS_W-1:0]           path_col
);

	localparam int SB       = SAMPLE_BITS;
	localparam int BAND_W   = 2 * MAX_RADIUS + 1;
	localparam int PATH_CAP = 2 * MAX_LEN - 1;
	localparam int IW       = $clog2(MAX_LEN);
	localparam int CNT_W    = $clog2(MAX_LEN + 1);
	localparam int KW       = $clog2(BAND_W + 1);
	localparam int TAW      = $clog2(MAX_LEN * BAND_W);
	localparam int CAW      = $clog2(2 * BAND_W);
	localparam int PAW      = $clog2(PATH_CAP);
	localparam int PLW      = $clog2(PATH_CAP + 1);
	localparam int XW       = (PLW > bdtw_pkg::STEP_W) ? PLW + 1 : bdtw_pkg::STEP_W + 1;
	localparam int DW       = IW + KW + 2;
	localparam int SQ_W     = 2 * SB + 2;
	localparam int CW       = (SQ_W > bdtw_pkg::COST_SAT_W) ? SQ_W : bdtw_pkg::COST_SAT_W;
	localparam int PEW      = 2 * bdtw_pkg::PPOS_W;
	localparam int CMPW     = 10;
	localparam logic [CW-1:0] INF = CW'(bdtw_pkg::COST_INF);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_RESP    = 4'd1;
	localparam logic [3:0] ST_PREAD   = 4'd2;
	localparam logic [3:0] ST_C_ROW   = 4'd3;
	localparam logic [3:0] ST_C_RD0   = 4'd4;
	localparam logic [3:0] ST_C_RD1   = 4'd5;
	localparam logic [3:0] ST_C_SQ    = 4'd6;
	localparam logic [3:0] ST_C_WR    = 4'd7;
	localparam logic [3:0] ST_SQ_GO   = 4'd8;
	localparam logic [3:0] ST_SQ_WAIT = 4'd9;
	localparam logic [3:0] ST_T_INIT  = 4'd10;
	localparam logic [3:0] ST_T_RD    = 4'd11;
	localparam logic [3:0] ST_T_EV    = 4'd12;
	localparam logic [3:0] ST_T_DONE  = 4'd13;

	logic [3:0]                     state_q;
	logic [bdtw_pkg::RADIUS_W-1:0]  band_radius_q;
	logic [CNT_W-1:0]               load_cnt_q;
	logic [IW-1:0]                  mlast_q;
	logic [KW-1:0]                  r_q;
	logic [KW-1:0]                  two_r_q;
	logic [IW-1:0]                  i_q;
	logic [IW-1:0]                  j_q;
	logic [IW-1:0]                  jhi_q;
	logic [KW-1:0]                  k_q;
	logic [TAW-1:0]                 tr_base_q;
	logic [CW-1:0]                  left_q;
	logic [CW-1:0]                  diag_q;
	logic [SB:0]                    ad_q;
	logic [SQ_W-1:0]                sq_q;
	logic [PLW-1:0]                 path_n_q;
	logic [PLW-1:0]                 path_len_q;
	logic [bdtw_pkg::COST_SUM_W-1:0] cost_q;
	logic [bdtw_pkg::DIST_W-1:0]    dist_q;
	logic [bdtw_pkg::STATUS_W-1:0]  pend_status_q;

	logic                           out_valid_q;
	logic [bdtw_pkg::STATUS_W-1:0]  status_q;
	logic [bdtw_pkg::COST_SUM_W-1:0] cost_sum_q;
	logic [bdtw_pkg::DIST_W-1:0]    distance_q;
	logic [bdtw_pkg::PLEN_W-1:0]    path_length_q;
	logic [bdtw_pkg::PPOS_W-1:0]    path_row_q;
	logic [bdtw_pkg::PPOS_W-1:0]    path_col_q;

	logic signed [SB-1:0] mem_a [0:MAX_LEN-1];
	logic signed [SB-1:0] mem_b [0:MAX_LEN-1];
	logic [CW-1:0]        cost_mem [0:2*BAND_W-1];
	logic [bdtw_pkg::TR_W-1:0] tr_mem [0:MAX_LEN*BAND_W-1];
	logic [PEW-1:0]       path_mem [0:PATH_CAP-1];

	logic signed [SB-1:0] a_in;
	logic signed [SB-1:0] b_in;
	logic signed [SB-1:0] a_rd_q;
	logic signed [SB-1:0] b_rd_q;
	logic [CW-1:0]        c_rd_q;
	logic [bdtw_pkg::TR_W-1:0] tr_rd_q;
	logic [PEW-1:0]       p_rd_q;

	logic                 in_acc;
	logic                 load_ok;
	logic                 ser_we;
	logic                 idx_bad;
	logic [KW-1:0]        r_sel;
	logic [KW-1:0]        k_up;
	logic [CAW-1:0]       c_raddr;
	logic [CAW-1:0]       c_waddr;
	logic [TAW-1:0]       tr_addr;
	logic [PAW-1:0]       p_raddr;
	logic [PAW-1:0]       p_waddr;
	logic [PEW-1:0]       p_wdata;
	logic                 p_we;

	logic signed [SB:0]   diff;
	logic [SB:0]          ad;
	logic [CW-1:0]        up_c;
	logic [CW-1:0]        diag_c;
	logic [CW-1:0]        d_c;
	logic [CW-1:0]        min_ld;
	logic [CW-1:0]        min_ud;
	logic [CW-1:0]        best;
	logic [CW-1:0]        sum_sat;
	logic [CW-1:0]        new_cost;
	logic [bdtw_pkg::TR_W-1:0] code;
	logic [bdtw_pkg::TR_W-1:0] new_code;
	logic                 first_cell;
	logic                 row_end;
	logic                 dp_end;

	logic [DW-1:0]        ii;
	logic [DW-1:0]        rr;
	logic [DW-1:0]        ml;
	logic [DW-1:0]        jlo;
	logic [DW-1:0]        k0;
	logic [DW-1:0]        jhi;

	logic [IW-1:0]        ni;
	logic [IW-1:0]        nj;
	logic [KW-1:0]        nk;
	logic                 tb_brk;
	logic                 tb_stop;

	logic                 sq_start;
	logic                 sq_done;
	logic [bdtw_pkg::DIST_W-1:0] sq_root;

	generate
		if (SB <= bdtw_pkg::SAMPLE_W) begin : g_narrow
			assign a_in = sample_a[SB-1:0];
			assign b_in = sample_b[SB-1:0];
		end else begin : g_wide
			assign a_in = {{(SB - bdtw_pkg::SAMPLE_W){sample_a[bdtw_pkg::SAMPLE_W-1]}}, sample_a};
			assign b_in = {{(SB - bdtw_pkg::SAMPLE_W){sample_b[bdtw_pkg::SAMPLE_W-1]}}, sample_b};
		end
	endgenerate

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign load_ok   = load_cnt_q < CNT_W'(MAX_LEN);
	assign ser_we    = in_acc && !kind && load_ok;
	assign idx_bad   = (XW'(step_index) >= XW'(path_len_q)) || (XW'(step_index) >= XW'(PATH_CAP));
	assign r_sel     = (CMPW'(band_radius_q) > CMPW'(MAX_RADIUS)) ? KW'(MAX_RADIUS)
	                                                              : KW'(band_radius_q);

	// row bounds
	assign ii  = DW'(i_q);
	assign rr  = DW'(r_q);
	assign ml  = DW'(mlast_q);
	assign jlo = (ii > rr) ? ii - rr : '0;
	assign k0  = (rr > ii) ? rr - ii : '0;
	assign jhi = (ii + rr < ml) ? ii + rr : ml;

	// prev row lives in the bank of the other parity
	assign k_up    = (k_q == two_r_q) ? k_q : k_q + 1'b1;
	assign c_raddr = (i_q[0] ? CAW'(0) : CAW'(BAND_W)) + CAW'((state_q == ST_C_RD0) ? k_q : k_up);
	assign c_waddr = (i_q[0] ? CAW'(BAND_W) : CAW'(0)) + CAW'(k_q);
	assign tr_addr = tr_base_q + TAW'(k_q);

	// cell evaluation
	assign diff    = {a_rd_q[SB-1], a_rd_q} - {b_rd_q[SB-1], b_rd_q};
	assign ad      = diff[SB] ? (~diff + 1'b1) : diff;
	assign d_c     = CW'(sq_q);
	assign up_c    = (i_q == '0 || k_q == two_r_q) ? INF : c_rd_q;
	assign diag_c  = (i_q == '0 || j_q == '0) ? INF : diag_q;
	assign min_ld  = (left_q < diag_c) ? left_q : diag_c;
	assign min_ud  = (up_c < diag_c) ? up_c : diag_c;

	always_comb begin
		if (up_c <= min_ld) begin
			code = bdtw_pkg::TR_UP;
			best = up_c;
		end else if (left_q <= min_ud) begin
			code = bdtw_pkg::TR_LEFT;
			best = left_q;
		end else begin
			code = bdtw_pkg::TR_DIAG;
			best = diag_c;
		end
	end

	assign sum_sat    = ((best >= INF) || (d_c >= INF - best)) ? INF : best + d_c;
	assign first_cell = (i_q == '0) && (j_q == '0);
	assign new_cost   = first_cell ? d_c : sum_sat;
	assign new_code   = first_cell ? bdtw_pkg::TR_LEFT : code;
	assign row_end    = j_q == jhi_q;
	assign dp_end     = row_end && (i_q == mlast_q);

	// traceback step
	always_comb begin
		ni     = i_q;
		nj     = j_q;
		nk     = k_q;
		tb_brk = 1'b0;
		unique case (tr_rd_q)
			bdtw_pkg::TR_LEFT: begin
				nk     = k_q - 1'b1;
				nj     = j_q - 1'b1;
				tb_brk = (k_q == '0) || (j_q == '0);
			end
			bdtw_pkg::TR_DIAG: begin
				ni     = i_q - 1'b1;
				nj     = j_q - 1'b1;
				tb_brk = (i_q == '0) || (j_q == '0);
			end
			default: begin
				ni     = i_q - 1'b1;
				nk     = k_q + 1'b1;
				tb_brk = (i_q == '0) || (k_q == two_r_q);
			end
		endcase
	end

	assign tb_stop = ((i_q == '0) && (k_q == r_q)) || (path_n_q >= PLW'(PATH_CAP));

	assign p_raddr = PAW'(step_index);
	assign p_we    = (state_q == ST_T_INIT) || (state_q == ST_T_EV && !tb_brk);
	assign p_waddr = (state_q == ST_T_INIT) ? '0 : PAW'(path_n_q);
	assign p_wdata = (state_q == ST_T_INIT) ? {8'(mlast_q), 8'(mlast_q)} : {8'(ni), 8'(nj)};
	assign sq_start = state_q == ST_SQ_GO;

	bdtw_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (cost_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// memories
	always_ff @(posedge clk) begin
		if (ser_we) begin
			mem_a[load_cnt_q[IW-1:0]] <= a_in;
			mem_b[load_cnt_q[IW-1:0]] <= b_in;
		end
		a_rd_q <= mem_a[i_q];
		b_rd_q <= mem_b[j_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_C_WR) begin
			cost_mem[c_waddr] <= new_cost;
		end
		c_rd_q <= cost_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_C_WR) begin
			tr_mem[tr_addr] <= new_code;
		end
		tr_rd_q <= tr_mem[tr_addr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			path_mem[p_waddr] <= p_wdata;
		end
		p_rd_q <= path_mem[p_raddr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_C_RD1) begin
			diag_q <= c_rd_q;
			ad_q   <= ad;
		end
		if (state_q == ST_C_SQ) begin
			sq_q <= SQ_W'(ad_q) * SQ_W'(ad_q);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			band_radius_q <= '0;
			load_cnt_q    <= '0;
			mlast_q       <= '0;
			r_q           <= '0;
			two_r_q       <= '0;
			i_q           <= '0;
			j_q           <= '0;
			jhi_q         <= '0;
			k_q           <= '0;
			tr_base_q     <= '0;
			left_q        <= '0;
			path_n_q      <= '0;
			path_len_q    <= '0;
			cost_q        <= '0;
			dist_q        <= '0;
			pend_status_q <= bdtw_pkg::STATUS_OK;
			out_valid_q   <= 1'b0;
			status_q      <= '0;
			cost_sum_q    <= '0;
			distance_q    <= '0;
			path_length_q <= '0;
			path_row_q    <= '0;
			path_col_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				band_radius_q <= band_radius;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (sq_done) begin
				dist_q <= sq_root;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!kind) begin
							if (!load_ok) begin
								pend_status_q <= bdtw_pkg::STATUS_OVERFLOW;
								if (last_pair) begin
									load_cnt_q <= '0;
								end
								state_q <= ST_RESP;
							end else if (last_pair) begin
								load_cnt_q <= '0;
								mlast_q    <= IW'(load_cnt_q);
								r_q        <= r_sel;
								two_r_q    <= KW'({r_sel, 1'b0});
								i_q        <= '0;
								tr_base_q  <= '0;
								state_q    <= ST_C_ROW;
							end else begin
								load_cnt_q <= load_cnt_q + 1'b1;
							end
						end else if (idx_bad) begin
							pend_status_q <= bdtw_pkg::STATUS_BAD_INDEX;
							state_q       <= ST_RESP;
						end else begin
							state_q <= ST_PREAD;
						end
					end
				end
				ST_RESP: begin
					out_valid_q   <= 1'b1;
					status_q      <= pend_status_q;
					cost_sum_q    <= cost_q;
					distance_q    <= dist_q;
					path_length_q <= bdtw_pkg::PLEN_W'(path_len_q);
					path_row_q    <= '0;
					path_col_q    <= '0;
					state_q       <= ST_IDLE;
				end
				ST_PREAD: begin
					out_valid_q   <= 1'b1;
					status_q      <= bdtw_pkg::STATUS_OK;
					cost_sum_q    <= cost_q;
					distance_q    <= dist_q;
					path_length_q <= bdtw_pkg::PLEN_W'(path_len_q);
					path_row_q    <= p_rd_q[PEW-1 -: bdtw_pkg::PPOS_W];
					path_col_q    <= p_rd_q[bdtw_pkg::PPOS_W-1:0];
					state_q       <= ST_IDLE;
				end
				ST_C_ROW: begin
					j_q     <= IW'(jlo);
					k_q     <= KW'(k0);
					jhi_q   <= IW'(jhi);
					left_q  <= INF;
					state_q <= ST_C_RD0;
				end
				ST_C_RD0: begin
					state_q <= ST_C_RD1;
				end
				ST_C_RD1: begin
					state_q <= ST_C_SQ;
				end
				ST_C_SQ: begin
					state_q <= ST_C_WR;
				end
				ST_C_WR: begin
					left_q <= new_cost;
					if (dp_end) begin
						cost_q  <= new_cost[bdtw_pkg::COST_SUM_W-1:0];
						state_q <= ST_SQ_GO;
					end else if (row_end) begin
						i_q       <= i_q + 1'b1;
						tr_base_q <= tr_base_q + TAW'(BAND_W);
						state_q   <= ST_C_ROW;
					end else begin
						j_q     <= j_q + 1'b1;
						k_q     <= k_q + 1'b1;
						state_q <= ST_C_RD0;
					end
				end
				ST_SQ_GO: begin
					state_q <= ST_SQ_WAIT;
				end
				ST_SQ_WAIT: begin
					if (sq_done) begin
						state_q <= ST_T_INIT;
					end
				end
				ST_T_INIT: begin
					i_q      <= mlast_q;
					j_q      <= mlast_q;
					k_q      <= r_q;
					path_n_q <= PLW'(1);
					state_q  <= ST_T_RD;
				end
				ST_T_RD: begin
					state_q <= tb_stop ? ST_T_DONE : ST_T_EV;
				end
				ST_T_EV: begin
					if (tb_brk) begin
						state_q <= ST_T_DONE;
					end else begin
						i_q      <= ni;
						j_q      <= nj;
						k_q      <= nk;
						path_n_q <= path_n_q + 1'b1;
						if (tr_rd_q != bdtw_pkg::TR_LEFT) begin
							tr_base_q <= tr_base_q - TAW'(BAND_W);
						end
						state_q <= ST_T_RD;
					end
				end
				ST_T_DONE: begin
					path_len_q    <= path_n_q;
					pend_status_q <= bdtw_pkg::STATUS_OK;
					state_q       <= ST_RESP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign cost_sum    = cost_sum_q;
	assign distance    = distance_q;
	assign path_length = path_length_q;
	assign path_row    = path_row_q;
	assign path_col    = path_col_q;

	assert property (@(posedge clk) disable iff (!arst_n) load_cnt_q <= CNT_W'(MAX_LEN))
		else $error("load count beyond series capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C_WR) |-> ((k_q <= two_r_q) && (j_q <= jhi_q)))
		else $error("band cell outside the band");
	assert property (@(posedge clk) disable iff (!arst_n) path_n_q <= PLW'(PATH_CAP))
		else $error("path count beyond path capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESP) || (state_q == ST_PREAD)) |-> !out_valid_q)
		else $error("result written over an untaken result");

endmodule

/* hdl/bdtw_isqrt.sv */
// ----------------------------------------------------------------------------
// bdtw_isqrt
// Floor square root, one result bit per cycle, restoring digit method.
// ----------------------------------------------------------------------------
module bdtw_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [bdtw_pkg::COST_SUM_W-1:0]  value,
	output logic                             done,
	output logic [bdtw_pkg::DIST_W-1:0]      root
);

	localparam int RW  = bdtw_pkg::DIST_W;
	localparam int VW  = bdtw_pkg::COST_SUM_W;
	localparam int RMW = RW + 2;
	localparam int CNW = $clog2(RW);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [RMW-1:0] rem_q;
	logic [RW-1:0]  root_q;
	logic [VW-1:0]  val_q;
	logic [RMW+1:0] rem_n;
	logic [RMW+1:0] trial;
	logic           fits;

	assign rem_n = {rem_q, val_q[VW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[VW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= RMW'(rem_n - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= RMW'(rem_n);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("root reported while still iterating");
	assert property (@(posedge clk) disable iff (!arst_n) (busy_q && !start) |=> (done_q || busy_q))
		else $error("iteration stopped without result");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> (busy_q && cnt_q == CNW'(RW - 1)))
		else $error("start did not load the iteration count");

endmodule

/* dv/banded_dtw_distance_with_path_unit_tb.sv */
// ----------------------------------------------------------------------------
// banded_dtw_distance_with_path_unit_tb
// Self-checking bench: loads series at several band radii, reads back warping
// path steps, checks answers against fixed directed values or a local model
// of the banded DTW fill and traceback, with random idling on both channels.
// ----------------------------------------------------------------------------
module banded_dtw_distance_with_path_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_CAP  = bdtw_pkg::MAX_LEN_DEF;
	localparam int RAD_CAP  = bdtw_pkg::MAX_RADIUS_DEF;
	localparam int BAND     = 2 * RAD_CAP + 1;
	localparam int PATH_CAP = 2 * LEN_CAP - 1;
	localparam int SW       = bdtw_pkg::SAMPLE_W;
	localparam int XW       = bdtw_pkg::STEP_W;
	localparam int PW       = bdtw_pkg::PPOS_W;
	localparam longint unsigned INF41 = (64'd1 << 41) - 64'd1;
	localparam bit KIND_LOAD = 1'b0;
	localparam bit KIND_READ = 1'b1;

	typedef struct packed {
		logic [bdtw_pkg::STATUS_W-1:0]   st;
		logic [bdtw_pkg::COST_SUM_W-1:0] cost;
		logic [bdtw_pkg::DIST_W-1:0]     droot;
		logic [bdtw_pkg::PLEN_W-1:0]     plen;
		logic [PW-1:0]                   row;
		logic [PW-1:0]                   col;
	} dtw_answer_t;

	typedef struct packed {
		bit              kd;
		logic [SW-1:0]   a;
		logic [SW-1:0]   b;
		bit              lst;
		logic [XW-1:0]   idx;
		bit              fixed;
		dtw_answer_t     ans;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bdtw_pkg::RADIUS_W-1:0] band_radius = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic signed [SW-1:0] sample_a = '0;
	logic signed [SW-1:0] sample_b = '0;
	logic last_pair = 1'b0;
	logic [XW-1:0] step_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [bdtw_pkg::STATUS_W-1:0] status;
	logic [bdtw_pkg::COST_SUM_W-1:0] cost_sum;
	logic [bdtw_pkg::DIST_W-1:0] distance;
	logic [bdtw_pkg::PLEN_W-1:0] path_length;
	logic [PW-1:0] path_row;
	logic [PW-1:0] path_col;

	banded_dtw_distance_with_path_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .band_radius(band_radius),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.sample_a(sample_a), .sample_b(sample_b), .last_pair(last_pair),
		.step_index(step_index),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.cost_sum(cost_sum), .distance(distance), .path_length(path_length),
		.path_row(path_row), .path_col(path_col)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the block state
	int              radius_q;
	logic signed [SW-1:0] ser_a [LEN_CAP];
	logic signed [SW-1:0] ser_b [LEN_CAP];
	int              held_pairs;
	longint unsigned rows [2][BAND];
	logic [bdtw_pkg::TR_W-1:0] trace_mem [LEN_CAP*BAND];
	logic [PW-1:0]   walk_row [PATH_CAP];
	logic [PW-1:0]   walk_col [PATH_CAP];
	longint unsigned best_cost;
	int              walk_len;

	dtw_answer_t answers_due [$];
	int  mismatches = 0;
	int  n_items = 0;
	bit  quiet = 1'b0;
	int  hold_asks = 0;
	int  hold_served = 0;
	int  hold_cycles = 0;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned sat_add(longint unsigned x, longint unsigned y);
		if (x >= INF41 || y >= INF41 - x) return INF41;
		return x + y;
	endfunction

	task automatic warp_fill(int m);
		int r, cs, jlo, jhi, k, t, i, n;
		longint sd;
		longint unsigned d, up, left, diag, best, mn;
		logic [bdtw_pkg::TR_W-1:0] code;
		r = (radius_q > RAD_CAP) ? RAD_CAP : radius_q;
		cs = 0;
		for (k = 0; k < BAND; k++) begin
			rows[0][k] = INF41;
			rows[1][k] = INF41;
		end
		for (i = 0; i < m; i++) begin
			jlo = (i > r) ? i - r : 0;
			jhi = (i + r < m - 1) ? i + r : m - 1;
			for (int j = jlo; j <= jhi; j++) begin
				k = j - i + r;
				sd = longint'(ser_a[i]) - longint'(ser_b[j]);
				if (sd < 0) sd = -sd;
				d = longint'(sd) * longint'(sd);
				if (i == 0 && j == 0) begin
					rows[cs][k] = d;
					trace_mem[r] = bdtw_pkg::TR_LEFT;
					continue;
				end
				left = (j == 0 || k == 0) ? INF41 : rows[cs][k-1];
				up   = (i == 0 || k + 1 > 2 * r) ? INF41 : rows[cs^1][k+1];
				diag = (i == 0 || j == 0) ? INF41 : rows[cs^1][k];
				best = (up < left) ? up : left;
				if (diag < best) best = diag;
				rows[cs][k] = sat_add(best, d);
				mn = (left < diag) ? left : diag;
				if (up <= mn) code = bdtw_pkg::TR_UP;
				else if (left <= ((up < diag) ? up : diag)) code = bdtw_pkg::TR_LEFT;
				else code = bdtw_pkg::TR_DIAG;
				trace_mem[i*BAND + k] = code;
			end
			cs ^= 1;
		end
		best_cost = rows[cs^1][r];
		i = m - 1;
		k = r;
		walk_row[0] = PW'(i);
		walk_col[0] = PW'(i);
		n = 1;
		while (!(i == 0 && k == r) && n < PATH_CAP) begin
			t = int'(trace_mem[i*BAND + k]);
			if (t == int'(bdtw_pkg::TR_LEFT)) k--;
			else if (t == int'(bdtw_pkg::TR_DIAG)) i--;
			else begin
				i--;
				k++;
			end
			if (i < 0 || k < 0 || k > 2 * r || i + k - r < 0) break;
			walk_row[n] = PW'(i);
			walk_col[n] = PW'(i + k - r);
			n++;
		end
		walk_len = n;
	endtask

	// returns 1 when the request yields an answer
	task automatic dtw_predict(bit kd, logic [SW-1:0] a, logic [SW-1:0] b, bit lst,
			logic [XW-1:0] idx, output bit has, output dtw_answer_t ans);
		ans = '0;
		has = 1'b1;
		if (kd == KIND_LOAD) begin
			if (held_pairs >= LEN_CAP) begin
				ans.st = bdtw_pkg::STATUS_OVERFLOW;
				if (lst) held_pairs = 0;
			end else begin
				ser_a[held_pairs] = a;
				ser_b[held_pairs] = b;
				held_pairs++;
				if (!lst) begin
					has = 1'b0;
					return;
				end
				warp_fill(held_pairs);
				held_pairs = 0;
				ans.st = bdtw_pkg::STATUS_OK;
			end
		end else if (int'(idx) >= walk_len) begin
			ans.st = bdtw_pkg::STATUS_BAD_INDEX;
		end else begin
			ans.st = bdtw_pkg::STATUS_OK;
			ans.row = walk_row[idx];
			ans.col = walk_col[idx];
		end
		ans.cost = best_cost[bdtw_pkg::COST_SUM_W-1:0];
		ans.droot = bdtw_pkg::DIST_W'(floor_root(best_cost & ((64'd1 << 40) - 1)));
		ans.plen = bdtw_pkg::PLEN_W'(walk_len);
	endtask

	task automatic issue(bit kd, logic [SW-1:0] a, logic [SW-1:0] b, bit lst,
			logic [XW-1:0] idx, bit fixed = 1'b0, dtw_answer_t fixed_ans = '0);
		int gap;
		bit has;
		dtw_answer_t ans;
		gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= kd;
		sample_a <= a;
		sample_b <= b;
		last_pair <= lst;
		step_index <= idx;
		do @(posedge clk); while (in_stall);
		n_items++;
		dtw_predict(kd, a, b, lst, idx, has, ans);
		if (has) answers_due.push_back(fixed ? fixed_ans : ans);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		wait (answers_due.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_radius(int r);
		go_idle();
		cfg_valid <= 1'b1;
		band_radius <= bdtw_pkg::RADIUS_W'(r);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_q = r;
	endtask

	task automatic load_series(int len, bit narrow);
		logic [SW-1:0] a, b;
		for (int p = 0; p < len; p++) begin
			a = narrow ? SW'($urandom_range(6) - 3) : SW'($urandom);
			b = narrow ? SW'($urandom_range(6) - 3) : SW'($urandom);
			issue(KIND_LOAD, a, b, p == len - 1, XW'($urandom));
		end
	endtask

	task automatic read_steps(int cnt);
		for (int q = 0; q < cnt; q++)
			issue(KIND_READ, SW'($urandom), SW'($urandom), $urandom_range(1),
				($urandom_range(9) == 0) ? XW'($urandom_range(510))
					: XW'($urandom_range(walk_len + 1)));
	endtask

	// receiver side
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served <= hold_asks;
			hold_cycles <= 299;
			out_stall   <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			dtw_answer_t got, want;
			got = '{status, cost_sum, distance, path_length, path_row, path_col};
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected answer %p", got);
			end else begin
				want = answers_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		dir_row_t dir_tab [10];
		int rl [6];
		int ph;
		radius_q = 0;
		held_pairs = 0;
		best_cost = 0;
		walk_len = 0;
		dir_tab[0] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd0, 1'b1,
			'{bdtw_pkg::STATUS_BAD_INDEX, 40'd0, 20'd0, 9'd0, 8'd0, 8'd0}};
		dir_tab[1] = '{KIND_READ, 16'hFFFF, 16'hFFFF, 1'b1, 9'd510, 1'b1,
			'{bdtw_pkg::STATUS_BAD_INDEX, 40'd0, 20'd0, 9'd0, 8'd0, 8'd0}};
		dir_tab[2] = '{KIND_LOAD, 16'h7FFF, 16'h8000, 1'b1, 9'd511, 1'b1,
			'{bdtw_pkg::STATUS_OK, 40'd4294836225, 20'd65535, 9'd1, 8'd0, 8'd0}};
		dir_tab[3] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd0, 1'b1,
			'{bdtw_pkg::STATUS_OK, 40'd4294836225, 20'd65535, 9'd1, 8'd0, 8'd0}};
		dir_tab[4] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd1, 1'b1,
			'{bdtw_pkg::STATUS_BAD_INDEX, 40'd4294836225, 20'd65535, 9'd1, 8'd0, 8'd0}};
		dir_tab[5] = '{KIND_LOAD, 16'h8000, 16'h8000, 1'b0, 9'd0, 1'b0, '0};
		dir_tab[6] = '{KIND_LOAD, 16'h7FFF, 16'h7FFF, 1'b1, 9'd0, 1'b1,
			'{bdtw_pkg::STATUS_OK, 40'd0, 20'd0, 9'd2, 8'd0, 8'd0}};
		dir_tab[7] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd0, 1'b1,
			'{bdtw_pkg::STATUS_OK, 40'd0, 20'd0, 9'd2, 8'd1, 8'd1}};
		dir_tab[8] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd1, 1'b0, '0};
		dir_tab[9] = '{KIND_READ, 16'h0000, 16'h0000, 1'b0, 9'd2, 1'b0, '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[n])
			issue(dir_tab[n].kd, dir_tab[n].a, dir_tab[n].b, dir_tab[n].lst, dir_tab[n].idx,
				dir_tab[n].fixed, dir_tab[n].ans);

		// ties and the three moves at a middling band
		set_radius(2);
		load_series(6, 1'b1);
		read_steps(4);

		// longest series at the widest band
		set_radius(RAD_CAP);
		load_series(LEN_CAP, 1'b0);
		read_steps(6);
		issue(KIND_READ, '0, '0, 1'b0, XW'(walk_len - 1));

		// too many pairs, series dropped, earlier results kept
		go_idle();
		for (int p = 0; p < LEN_CAP; p++)
			issue(KIND_LOAD, SW'($urandom_range(6) - 3), SW'($urandom_range(6) - 3), 1'b0, '0);
		issue(KIND_LOAD, SW'($urandom), SW'($urandom), 1'b0, '0);
		issue(KIND_LOAD, SW'($urandom), SW'($urandom), 1'b1, '0);
		read_steps(3);

		// receiver holds off while requests keep coming
		go_idle();
		hold_asks++;
		read_steps(8);
		load_series(5, 1'b0);

		rl = '{63, 0, 1, 32, 17, 0};
		ph = 0;
		while (n_items < 1050) begin
			set_radius((ph < 6) ? rl[ph] : $urandom_range(63));
			quiet = (ph == 3);
			for (int s = 0; s < 6; s++) begin
				load_series(($urandom_range(99) < 85) ? $urandom_range(12, 1)
					: $urandom_range(48, 13), $urandom_range(99) < 30);
				read_steps($urandom_range(3));
			end
			quiet = 1'b0;
			ph++;
		end

		in_valid <= 1'b0;
		wait (answers_due.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
